/* sv/pctd_pkg.sv */
// Shared types, codes and helpers for the percent decoder.
// Used by every module of the percent_decoder_unit block; depends on nothing.
package pctd_pkg;

	// ASCII percent sign
	localparam logic [7:0] PCT_CHAR = 8'h25;

	// Result buffer geometry
	localparam int unsigned BUF_DEPTH = 4;
	localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       text_end;
	} out_item_t;

	// Outcome of one decode step
	typedef struct packed {
		logic [1:0] n;
		out_item_t  r0;
		out_item_t  r1;
		phase_t     phase_nx;
		logic [3:0] held_nx;
	} step_t;

	// Hex digit test: bit 4 flags a digit, bits 3:0 hold its value
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

/* sv/pctd_step.sv */
// Combinational decode step: one input byte against the pending escape state.
// Depends on pctd_pkg.
module pctd_step (
	input  pctd_pkg::in_item_t  item,
	input  pctd_pkg::phase_t    phase,
	input  logic [3:0]          held,
	output pctd_pkg::step_t     step
);
	import pctd_pkg::*;

	logic [4:0] hx;
	logic       fin;
	logic [7:0] b;
	logic [7:0] by0;
	logic [7:0] by1;
	logic [1:0] n;
	phase_t     ph_nx;
	logic [3:0] held_nx;

	assign b   = item.in_byte;
	assign fin = item.final_byte;
	assign hx  = hex_value(b);

	// Decide the emitted bytes and next phase
	always_comb begin
		by0     = b;
		by1     = b;
		n       = 2'd0;
		ph_nx   = PH_IDLE;
		held_nx = held;
		unique case (phase)
			PH_PCT: begin
				if (fin) begin
					by0 = PCT_CHAR;
					n   = 2'd2;
				end else if (hx[4]) begin
					held_nx = hx[3:0];
					ph_nx   = PH_HEX;
				end else if (b == PCT_CHAR) begin
					by0   = PCT_CHAR;
					n     = 2'd1;
					ph_nx = PH_PCT;
				end else begin
					by0 = PCT_CHAR;
					n   = 2'd2;
				end
			end
			PH_HEX: begin
				by0 = hx[4] ? {held, hx[3:0]} : {4'd0, held};
				n   = 2'd1;
			end
			default: begin
				if (b == PCT_CHAR && !fin) begin
					ph_nx = PH_PCT;
				end else begin
					n = 2'd1;
				end
			end
		endcase
		if (fin) begin
			ph_nx   = PH_IDLE;
			held_nx = 4'd0;
		end
	end

	// Mark the last beat of this item
	always_comb begin
		step.n        = n;
		step.phase_nx = ph_nx;
		step.held_nx  = held_nx;
		step.r0       = '{out_byte: by0, run_end: (n == 2'd1),
		                  text_end: (n == 2'd1) && fin};
		step.r1       = '{out_byte: by1, run_end: 1'b1, text_end: fin};
	end

endmodule

/* sv/pctd_rbuf.sv */
// Small result buffer: takes up to two beats per cycle, sends one per cycle unless the result port stalls.
// Depends on pctd_pkg.
module pctd_rbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  pctd_pkg::out_item_t  push0,
	input  pctd_pkg::out_item_t  push1,
	output logic                 room,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pctd_pkg::out_item_t  result
);
	import pctd_pkg::*;

	out_item_t         mem_q [BUF_DEPTH];
	logic [BUF_AW-1:0] wr_q;
	logic [BUF_AW-1:0] rd_q;
	logic [BUF_AW:0]   cnt_q;
	logic              pop;
	logic [BUF_AW-1:0] wr1;

	assign pop          = result_valid && !result_stall;
	assign result_valid = (cnt_q != '0);
	assign result       = mem_q[rd_q];
	assign wr1          = wr_q + BUF_AW'(1);
	// Room for a two-beat item regardless of this cycle's pop
	assign room         = (cnt_q <= (BUF_AW+1)'(BUF_DEPTH - 2));

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr1] <= push1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + BUF_AW'(push_n);
			rd_q  <= rd_q + BUF_AW'(pop);
			cnt_q <= cnt_q + (BUF_AW+1)'(push_n) - (BUF_AW+1)'(pop);
		end
	end

endmodule

/* sv/percent_decoder_unit.sv */
// Top level of the streaming percent decoder.
// Depends on pctd_pkg, pctd_step and pctd_rbuf.
//
// Bytes enter one per beat, registered into one input stage; the decode
// step runs combinationally from that register into a four-beat result
// buffer. An item is taken every cycle while the buffer has room for two
// beats, so plain text flows at one byte per cycle unless the result port
// stalls, passing the input register and then the buffer on its way out.
// An item yields zero, one or two result beats; as the result port sends
// at most one beat per cycle, a run of two-beat items is paced by that port.
module percent_decoder_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  pctd_pkg::in_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pctd_pkg::out_item_t  result
);
	import pctd_pkg::*;

	in_item_t   item_s1;
	logic       valid_s1;
	phase_t     phase_q;
	logic [3:0] held_q;
	step_t      step;
	logic       room;
	logic       adv;
	logic [1:0] push_n;

	assign adv        = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign push_n     = adv ? step.n : 2'd0;

	// Input stage payload
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Input stage valid and decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			held_q   <= 4'd0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				phase_q <= step.phase_nx;
				held_q  <= step.held_nx;
			end
		end
	end

	pctd_step u_step (
		.item  (item_s1),
		.phase (phase_q),
		.held  (held_q),
		.step  (step)
	);

	pctd_rbuf u_rbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_n       (push_n),
		.push0        (step.r0),
		.push1        (step.r1),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* sv/pctd_checker.sv */
// Port-level checks for percent_decoder_unit, attached by bind.
// Depends on pctd_pkg.
module pctd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input pctd_pkg::in_item_t   item,
	input logic                 result_valid,
	input logic                 result_stall,
	input pctd_pkg::out_item_t  result
);
	import pctd_pkg::*;

	// Stall only with a byte held from an earlier beat
	a_stall_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> $past(item_valid && !item_stall) || $past(item_stall))
		else $error("input stall without a held byte");

	// End of text always closes the run
	a_text_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.text_end |-> result.run_end)
		else $error("text_end without run_end");

	// Hold a stalled result beat
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

endmodule

bind percent_decoder_unit pctd_checker u_pctd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
